// ----- sv/ffha_pkg.sv -----
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

	localparam int MAX_CHUNKS     = 64;
	localparam int HEADER_BYTES   = 32;
	localparam int HEAP_BYTES_MAX = 65536;
	localparam int AW             = 17;
	localparam int CW             = 7;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_NOMATCH = 2'd2
	} status_t;

	typedef struct packed {
		logic          tv;
		kind_t         kind;
		logic [AW-1:0] req;
		logic [AW-1:0] rel;
		logic          room;
		logic          hit;
		logic          split;
		logic [AW-1:0] res_off;
		logic          pend;
		logic          p_used;
		logic [AW-1:0] p_off;
		logic [AW-1:0] p_size;
	} tok_t;

endpackage

// ----- sv/ffha_cell.sv -----
// One chunk cell of the address-ordered chain.
module ffha_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  first,
	input  logic                  init,
	input  logic [ffha_pkg::AW-1:0] init_size,
	input  ffha_pkg::tok_t        tok_i,
	output ffha_pkg::tok_t        tok_o
);

	logic                    vld_q, vld_d;
	logic                    used_q, used_d;
	logic [ffha_pkg::AW-1:0] off_q, off_d;
	logic [ffha_pkg::AW-1:0] size_q, size_d;
	ffha_pkg::tok_t          tok_q, tok_d;
	logic                    match;
	logic [ffha_pkg::AW:0]   need;
	logic                    big;

	always_comb begin
		need  = {1'b0, tok_i.req} + (ffha_pkg::AW+1)'(ffha_pkg::HEADER_BYTES);
		big   = {1'b0, size_q} > need;
		match = vld_q && ((tok_i.kind == ffha_pkg::KIND_ALLOC) ?
			(!used_q && size_q >= tok_i.req) : (off_q == tok_i.rel));
		vld_d  = vld_q;
		used_d = used_q;
		off_d  = off_q;
		size_d = size_q;
		tok_d  = tok_i;
		if (tok_i.tv) begin
			if (!tok_i.hit && match) begin
				tok_d.hit     = 1'b1;
				tok_d.res_off = off_q;
				if (tok_i.kind == ffha_pkg::KIND_ALLOC) begin
					used_d = 1'b1;
					if (big && tok_i.room) begin
						size_d       = tok_i.req;
						tok_d.split  = 1'b1;
						tok_d.pend   = 1'b1;
						tok_d.p_used = 1'b0;
						tok_d.p_off  = off_q + ffha_pkg::AW'(ffha_pkg::HEADER_BYTES)
							+ tok_i.req;
						tok_d.p_size = size_q - ffha_pkg::AW'(ffha_pkg::HEADER_BYTES)
							- tok_i.req;
					end
				end else begin
					used_d = 1'b0;
				end
			end else if (tok_i.pend) begin
				vld_d        = 1'b1;
				used_d       = tok_i.p_used;
				off_d        = tok_i.p_off;
				size_d       = tok_i.p_size;
				tok_d.pend   = vld_q;
				tok_d.p_used = used_q;
				tok_d.p_off  = off_q;
				tok_d.p_size = size_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= first;
			used_q <= 1'b0;
			off_q  <= '0;
			size_q <= ffha_pkg::AW'(ffha_pkg::HEAP_BYTES_MAX);
			tok_q  <= '0;
		end else if (init) begin
			vld_q  <= first;
			used_q <= 1'b0;
			off_q  <= '0;
			size_q <= init_size;
			tok_q  <= '0;
		end else begin
			vld_q  <= vld_d;
			used_q <= used_d;
			off_q  <= off_d;
			size_q <= size_d;
			tok_q  <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: cell chain and result queue.
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_ready   | kind, request_size, release_offset
//  out     | output    | out_valid / out_ready | status, chunk_offset, data_offset, chunk_count
//  cfg     | input     | cfg_we                | cfg_wdata (heap size)
// An item's word rides one cell per cycle down the chain, then enters the result queue,
// and the next word is taken only after that, once the queue has room.
// One item is in the chain at a time; a two-word result queue lets a new item enter
// while a result waits. Reset and a cfg write leave one free chunk of the heap size.
// A stalled output holds its word; input stalls while the chain or queue is full.
module first_fit_heap_allocator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [ffha_pkg::AW-1:0]   request_size,
	input  logic [ffha_pkg::AW-1:0]   release_offset,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [ffha_pkg::AW-1:0]   chunk_offset,
	output logic [ffha_pkg::AW-1:0]   data_offset,
	output logic [ffha_pkg::CW-1:0]   chunk_count,
	input  logic                      cfg_we,
	input  logic [ffha_pkg::AW-1:0]   cfg_wdata
);

	typedef struct packed {
		logic [1:0]              st;
		logic [ffha_pkg::AW-1:0] co;
		logic [ffha_pkg::AW-1:0] dof;
		logic [ffha_pkg::CW-1:0] cc;
	} res_t;

	ffha_pkg::tok_t          links [0:ffha_pkg::MAX_CHUNKS];
	ffha_pkg::tok_t          launch, fin;
	logic [ffha_pkg::AW-1:0] init_size;
	logic [ffha_pkg::CW-1:0] count_q;
	logic [1:0]              qcnt_q;
	logic                    busy_q;
	res_t                    head_q, tail_q, res;
	logic                    acc, push, pop;

	assign in_ready  = !busy_q && qcnt_q < 2'd2;
	assign acc       = in_valid && in_ready;
	assign init_size = (cfg_wdata > ffha_pkg::AW'(ffha_pkg::HEAP_BYTES_MAX)) ?
		ffha_pkg::AW'(ffha_pkg::HEAP_BYTES_MAX) : cfg_wdata;

	always_comb begin
		launch      = '0;
		launch.tv   = acc;
		launch.kind = ffha_pkg::kind_t'(kind);
		launch.req  = request_size;
		launch.rel  = release_offset;
		launch.room = count_q < ffha_pkg::CW'(ffha_pkg::MAX_CHUNKS);
	end

	assign links[0] = launch;

	for (genvar i = 0; i < ffha_pkg::MAX_CHUNKS; i++) begin : g_cell
		ffha_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.first     (1'(i == 0)),
			.init      (cfg_we),
			.init_size (init_size),
			.tok_i     (links[i]),
			.tok_o     (links[i+1])
		);
	end

	assign fin  = links[ffha_pkg::MAX_CHUNKS];
	assign push = fin.tv;
	assign pop  = qcnt_q != 2'd0 && out_ready;

	always_comb begin
		res = '0;
		res.cc = count_q + ffha_pkg::CW'(fin.split);
		if (fin.hit) begin
			res.st  = ffha_pkg::ST_OK;
			res.co  = fin.res_off;
			res.dof = fin.res_off + ffha_pkg::AW'(ffha_pkg::HEADER_BYTES);
		end else begin
			res.st = (fin.kind == ffha_pkg::KIND_ALLOC) ? ffha_pkg::ST_NOFIT
				: ffha_pkg::ST_NOMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ffha_pkg::CW'(1);
			busy_q  <= 1'b0;
			qcnt_q  <= 2'd0;
		end else begin
			if (cfg_we) begin
				count_q <= ffha_pkg::CW'(1);
			end else if (push) begin
				count_q <= res.cc;
			end
			if (acc) begin
				busy_q <= 1'b1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
			qcnt_q <= qcnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && (qcnt_q == 2'd0 || (qcnt_q == 2'd1 && pop))) begin
			head_q <= res;
		end else if (pop && qcnt_q == 2'd2) begin
			head_q <= tail_q;
		end
		if (push && qcnt_q == 2'd1 && !pop) begin
			tail_q <= res;
		end
	end

	assign out_valid    = qcnt_q != 2'd0;
	assign status       = head_q.st;
	assign chunk_offset = head_q.co;
	assign data_offset  = head_q.dof;
	assign chunk_count  = head_q.cc;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> qcnt_q != 2'd2)
		else $error("result queue overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= ffha_pkg::CW'(ffha_pkg::MAX_CHUNKS))
		else $error("chunk count out of range");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> busy_q)
		else $error("result without item in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for first_fit_heap_allocator: directed table, then random phases.
module tb_top;

	localparam int MAX_CHUNKS     = ffha_pkg::MAX_CHUNKS;
	localparam int HEADER_BYTES   = ffha_pkg::HEADER_BYTES;
	localparam int HEAP_BYTES_MAX = ffha_pkg::HEAP_BYTES_MAX;
	localparam int AW             = ffha_pkg::AW;
	localparam int CW             = ffha_pkg::CW;
	localparam int CLK_HI      = 6;
	localparam int CLK_LO      = 6;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 120;
	localparam int DRAIN_WAIT  = 2 * MAX_CHUNKS + 16;
	localparam int END_SLOT    = MAX_CHUNKS;

	typedef struct {
		ffha_pkg::status_t st;
		bit [AW-1:0]       coff;
		bit [AW-1:0]       doff;
		bit [CW-1:0]       cnt;
	} grant_t;

	typedef struct {
		ffha_pkg::kind_t   k;
		int                req;
		int                rel;
		bit                typed;
		ffha_pkg::status_t st;
		int                coff;
		int                doff;
		int                cnt;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic          kind;
	logic [AW-1:0] request_size;
	logic [AW-1:0] release_offset;
	logic          out_valid;
	logic          out_ready;
	logic [1:0]    status;
	logic [AW-1:0] chunk_offset;
	logic [AW-1:0] data_offset;
	logic [CW-1:0] chunk_count;
	logic          cfg_we;
	logic [AW-1:0] cfg_wdata;

	// mirror of the chunk table
	int  heap_bytes;
	int  chunk_off  [MAX_CHUNKS];
	int  chunk_size [MAX_CHUNKS];
	bit  chunk_used [MAX_CHUNKS];
	int  chunk_next [MAX_CHUNKS];
	int  chunk_total;

	grant_t grants_due[$];
	int     fail_count;
	int     cycles;
	int     tx_idle_pct;
	int     rx_idle_pct;
	int     rx_hold;

	row_t plan[14] = '{
		'{ffha_pkg::KIND_ALLOC, 0,      0,      1, ffha_pkg::ST_OK,      0,  32, 2},
		'{ffha_pkg::KIND_ALLOC, 65536,  0,      1, ffha_pkg::ST_NOFIT,   0,  0,  2},
		'{ffha_pkg::KIND_ALLOC, 131071, 0,      1, ffha_pkg::ST_NOFIT,   0,  0,  2},
		'{ffha_pkg::KIND_FREE,  0,      0,      1, ffha_pkg::ST_OK,      0,  32, 2},
		'{ffha_pkg::KIND_FREE,  0,      131071, 1, ffha_pkg::ST_NOMATCH, 0,  0,  2},
		'{ffha_pkg::KIND_FREE,  0,      32,     1, ffha_pkg::ST_OK,      32, 64, 2},
		'{ffha_pkg::KIND_ALLOC, 0,      0,      1, ffha_pkg::ST_OK,      0,  32, 2},
		'{ffha_pkg::KIND_ALLOC, 100,    0,      0, ffha_pkg::ST_OK,      0,  0,  0},
		'{ffha_pkg::KIND_ALLOC, 65372,  0,      0, ffha_pkg::ST_OK,      0,  0,  0},
		'{ffha_pkg::KIND_FREE,  0,      164,    0, ffha_pkg::ST_OK,      0,  0,  0},
		'{ffha_pkg::KIND_ALLOC, 65373,  0,      0, ffha_pkg::ST_OK,      0,  0,  0},
		'{ffha_pkg::KIND_ALLOC, 1,      0,      0, ffha_pkg::ST_OK,      0,  0,  0},
		'{ffha_pkg::KIND_FREE,  0,      65535,  0, ffha_pkg::ST_OK,      0,  0,  0},
		'{ffha_pkg::KIND_ALLOC, 65535,  0,      0, ffha_pkg::ST_OK,      0,  0,  0}
	};

	first_fit_heap_allocator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.request_size   (request_size),
		.release_offset (release_offset),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.chunk_offset   (chunk_offset),
		.data_offset    (data_offset),
		.chunk_count    (chunk_count),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#CLK_HI;
		clk = 1'b0;
		#CLK_LO;
	end

	function automatic void restart_heap(int bytes);
		heap_bytes = (bytes > HEAP_BYTES_MAX) ? HEAP_BYTES_MAX : bytes;
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			chunk_off[i]  = 0;
			chunk_size[i] = 0;
			chunk_used[i] = 0;
			chunk_next[i] = 0;
		end
		chunk_size[0] = heap_bytes;
		chunk_next[0] = END_SLOT;
		chunk_total   = 1;
	endfunction

	function automatic grant_t place_chunk(ffha_pkg::kind_t k, int req, int rel);
		grant_t g;
		int     cur;
		int     ns;
		bit     found;
		cur   = 0;
		found = 0;
		for (int steps = 0; steps < MAX_CHUNKS && cur < END_SLOT; steps++) begin
			if (k == ffha_pkg::KIND_ALLOC) begin
				if (!chunk_used[cur] && chunk_size[cur] >= req) begin
					found = 1;
					break;
				end
			end else if (chunk_off[cur] == rel) begin
				found = 1;
				break;
			end
			cur = chunk_next[cur];
		end
		g.st   = ffha_pkg::ST_OK;
		g.coff = '0;
		g.doff = '0;
		if (!found) begin
			g.st = (k == ffha_pkg::KIND_ALLOC) ? ffha_pkg::ST_NOFIT : ffha_pkg::ST_NOMATCH;
		end else if (k == ffha_pkg::KIND_ALLOC) begin
			chunk_used[cur] = 1;
			if (chunk_size[cur] > req + HEADER_BYTES && chunk_total < MAX_CHUNKS) begin
				ns             = chunk_total;
				chunk_off[ns]  = chunk_off[cur] + HEADER_BYTES + req;
				chunk_size[ns] = chunk_size[cur] - HEADER_BYTES - req;
				chunk_used[ns] = 0;
				chunk_next[ns] = chunk_next[cur];
				chunk_next[cur] = ns;
				chunk_size[cur] = req;
				chunk_total    = ns + 1;
			end
			g.coff = AW'(chunk_off[cur]);
			g.doff = AW'(chunk_off[cur] + HEADER_BYTES);
		end else begin
			chunk_used[cur] = 0;
			g.coff = AW'(chunk_off[cur]);
			g.doff = AW'(chunk_off[cur] + HEADER_BYTES);
		end
		g.cnt = CW'(chunk_total);
		return g;
	endfunction

	// offer one word and hold it until accepted
	task automatic send_word(ffha_pkg::kind_t k, int req, int rel, bit typed, grant_t typed_g);
		grant_t g;
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		kind           <= k;
		request_size   <= req[AW-1:0];
		release_offset <= rel[AW-1:0];
		do
			@(posedge clk);
		while (!in_ready);
		g = place_chunk(k, req, rel);
		grants_due.push_back(typed ? typed_g : g);
	endtask

	task automatic write_heap(int bytes);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (grants_due.size() == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= bytes[AW-1:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		restart_heap(bytes);
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold   <= rx_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		grant_t g;
		if (arst_n && out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				$error("unexpected word: status %0d chunk_offset %0d", status, chunk_offset);
				fail_count++;
			end else begin
				g = grants_due.pop_front();
				if (status !== g.st) begin
					$error("status: expected %0d, got %0d", g.st, status);
					fail_count++;
				end
				if (chunk_offset !== g.coff) begin
					$error("chunk_offset: expected %0d, got %0d", g.coff, chunk_offset);
					fail_count++;
				end
				if (data_offset !== g.doff) begin
					$error("data_offset: expected %0d, got %0d", g.doff, data_offset);
					fail_count++;
				end
				if (chunk_count !== g.cnt) begin
					$error("chunk_count: expected %0d, got %0d", g.cnt, chunk_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		int     sizes[8];
		grant_t tg;
		int     req;
		int     rel;
		int     pick;
		sizes = '{65536, 0, 1500, 131071, 3000, 0, 65536, 800};
		sizes[5] = $urandom_range(131071);
		fail_count     = 0;
		cycles         = 0;
		tx_idle_pct    = 0;
		rx_idle_pct    = 0;
		rx_hold        = 0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		kind           = 1'b0;
		request_size   = '0;
		release_offset = '0;
		out_ready      = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		restart_heap(65536);
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			tg.st   = plan[i].st;
			tg.coff = AW'(plan[i].coff);
			tg.doff = AW'(plan[i].doff);
			tg.cnt  = CW'(plan[i].cnt);
			send_word(plan[i].k, plan[i].req, plan[i].rel, plan[i].typed, tg);
		end

		for (int ph = 0; ph < 8; ph++) begin
			write_heap(sizes[ph]);
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
				1: begin tx_idle_pct = 50; rx_idle_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_idle_pct = 50; end
				default: begin tx_idle_pct = 13; rx_idle_pct = 13; end
			endcase
			if (ph == 4)
				rx_hold = 600;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					rel = ($urandom_range(9) == 0) ? $urandom_range(131071)
						: chunk_off[$urandom_range(chunk_total - 1)];
					send_word(ffha_pkg::KIND_FREE, $urandom_range(131071), rel, 0, tg);
				end else begin
					if (pick < 75)
						req = $urandom_range(24);
					else if (pick < 94)
						req = $urandom_range(heap_bytes / 4);
					else
						req = $urandom_range(131071);
					send_word(ffha_pkg::KIND_ALLOC, req, $urandom_range(131071), 0, tg);
				end
			end
		end

		@(negedge clk);
		in_valid    <= 1'b0;
		rx_idle_pct = 0;
		wait (grants_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
